// File: hdl/sorted_timeout_timer_pool_core_defines.svh
// Assertion helpers for the timer pool checker.
`ifndef SORTED_TIMEOUT_TIMER_POOL_CORE_DEFINES_SVH
`define SORTED_TIMEOUT_TIMER_POOL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define STTP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define STTP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sttp_pkg.sv
package sttp_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int TIMER_W     = $clog2(NUM_TIMERS);
  localparam int MAX_RESULTS = 16;
  localparam int EXP_CNT_W   = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_SET   = 3'd2,
    OP_START = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_NONE    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_EXPIRED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } status_e;

  // Command broadcast to every cell of the sorted row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK,
    CELL_STEP,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic               vld;
    logic [TIMER_W-1:0] id;
    logic [31:0]        dl;
  } cell_t;

  typedef struct packed {
    cell_op_e           op;
    logic [TIMER_W-1:0] id;
    logic [31:0]        dl;
  } cell_cmd_t;

endpackage

// File: hdl/sttp_cell.sv
// One slot of the deadline-ordered row. Valid slots are packed at the front.
module sttp_cell import sttp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  cell_t     left_i,
  input  logic      left_ge_i,
  input  logic      left_hole_i,
  input  cell_t     right_i,
  output cell_t     cell_o,
  output logic      ge_o,
  output logic      hole_o
);

  logic               vld_q, vld_d;
  logic               hole_q, hole_d;
  logic [TIMER_W-1:0] id_q, id_d;
  logic [31:0]        dl_q, dl_d;

  // New deadline goes at or before this slot (ahead of equal deadlines)
  assign ge_o = !vld_q || (cmd_i.dl <= dl_q);

  always_comb begin
    vld_d  = vld_q;
    hole_d = hole_q;
    id_d   = id_q;
    dl_d   = dl_q;
    case (cmd_i.op)
      CELL_MARK: begin
        hole_d = vld_q && (id_q == cmd_i.id);
      end
      CELL_STEP: begin
        // hole walks toward the tail, pulling entries forward
        if (hole_q) begin
          vld_d  = right_i.vld;
          id_d   = right_i.id;
          dl_d   = right_i.dl;
          hole_d = 1'b0;
        end else if (left_hole_i && vld_q) begin
          hole_d = 1'b1;
        end
      end
      CELL_INSERT: begin
        if (ge_o) begin
          if (left_ge_i) begin
            vld_d = left_i.vld;
            id_d  = left_i.id;
            dl_d  = left_i.dl;
          end else begin
            vld_d = 1'b1;
            id_d  = cmd_i.id;
            dl_d  = cmd_i.dl;
          end
        end
      end
      CELL_POP: begin
        vld_d = right_i.vld;
        id_d  = right_i.id;
        dl_d  = right_i.dl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      hole_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      hole_q <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
  end

  assign cell_o = '{vld: vld_q, id: id_q, dl: dl_q};
  assign hole_o = hole_q;

endmodule

// File: hdl/sorted_timeout_timer_pool_core.sv
// Pool of one-shot timers sharing a 32-bit tick counter advanced by each tick operation.
// Input channel (in_valid_i/in_ready_o) carries one operation per transfer:
// allocate, free, set payload, start or tick. Output channel
// (out_valid_o/out_ready_i) returns result transfers; last_o marks the
// final result of an operation. One operation is in flight at a time:
// in_ready_o is high only while the controller is idle.
// Steps from input transfer to first result in the output register:
//   allocate, set payload, unknown op, idle free: S_EXEC, S_RESP.
//   start of a non-running timer: S_EXEC, S_INSERT, S_RESP.
//   free or restart of a running timer: S_EXEC, S_STEP while the hole
//   walks one cell per cycle down the sorted row, S_INSERT (restart), S_RESP.
//   tick: S_EXEC, then S_EXPIRE sends one expired timer per cycle through
//   the output register while the receiver keeps up, up to MAX_RESULTS per tick.
// The next input is taken the cycle after the last result is loaded, even
// while that result still waits for the receiver. A stalled receiver holds
// the output register and freezes the expiry walk.
// Reset clears the counter, marks all timers free and empties the row.
module sorted_timeout_timer_pool_core import sttp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  timer_id_o,
  output logic [31:0] expired_data_o,
  output logic        last_o
);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_EXPIRE = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_q, state_d;

  // operation held for the whole walk
  logic [2:0]         op_q;
  logic [TIMER_W-1:0] tid_q;
  logic               in_pool_q;
  logic [31:0]        dl_q;
  logic [31:0]        data_q;

  logic [31:0]          tick_q, tick_d;
  logic [TIMER_W-1:0]   step_q, step_d;
  logic [EXP_CNT_W-1:0] exp_cnt_q, exp_cnt_d;
  kind_e                resp_kind_q, resp_kind_d;
  logic [3:0]           resp_id_q, resp_id_d;

  status_e     status_q [NUM_TIMERS];
  logic [31:0] payload_q [NUM_TIMERS];

  logic               st_we;
  logic [TIMER_W-1:0] st_idx;
  status_e            st_val;
  logic               pl_we;

  // output register
  logic        out_valid_q;
  kind_e       out_kind_q, out_kind_d;
  logic [3:0]  out_id_q, out_id_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        out_load, out_free;

  // sorted row
  cell_cmd_t cmd;
  cell_t     cells [NUM_TIMERS];
  logic      ge    [NUM_TIMERS];
  logic      hole  [NUM_TIMERS];

  logic               accept;
  logic               alloc_found;
  logic [TIMER_W-1:0] alloc_sel;
  logic               head_exp, next_exp;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // lowest free timer
  always_comb begin
    alloc_found = 1'b0;
    alloc_sel   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (status_q[i] == ST_FREE) begin
        alloc_found = 1'b1;
        alloc_sel   = TIMER_W'(i);
      end
    end
  end

  // head expires now; does the one behind it expire as well
  assign head_exp = cells[0].vld && (cells[0].dl <= tick_q);
  assign next_exp = cells[1].vld && (cells[1].dl <= tick_q);

  generate
    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
      cell_t left_c, right_c;
      logic  left_ge, left_hole;
      if (k == 0) begin : g_first
        assign left_c    = '0;
        assign left_ge   = 1'b0;
        assign left_hole = 1'b0;
      end else begin : g_mid
        assign left_c    = cells[k-1];
        assign left_ge   = ge[k-1];
        assign left_hole = hole[k-1];
      end
      if (k == NUM_TIMERS - 1) begin : g_last
        assign right_c = '0;
      end else begin : g_body
        assign right_c = cells[k+1];
      end
      sttp_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .left_i      (left_c),
        .left_ge_i   (left_ge),
        .left_hole_i (left_hole),
        .right_i     (right_c),
        .cell_o      (cells[k]),
        .ge_o        (ge[k]),
        .hole_o      (hole[k])
      );
    end
  endgenerate

  // controller
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    step_d      = step_q;
    exp_cnt_d   = exp_cnt_q;
    resp_kind_d = resp_kind_q;
    resp_id_d   = resp_id_q;
    st_we       = 1'b0;
    st_idx      = tid_q;
    st_val      = ST_FREE;
    pl_we       = 1'b0;
    cmd         = '{op: CELL_HOLD, id: tid_q, dl: dl_q};
    out_load    = 1'b0;
    out_kind_d  = KIND_DONE;
    out_id_d    = 4'd0;
    out_data_d  = 32'd0;
    out_last_d  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        resp_kind_d = KIND_DONE;
        resp_id_d   = 4'd0;
        state_d     = S_RESP;
        case (op_q)
          OP_ALLOC: begin
            if (alloc_found) begin
              st_we       = 1'b1;
              st_idx      = alloc_sel;
              st_val      = ST_ALLOC;
              resp_kind_d = KIND_ALLOC;
              resp_id_d   = 4'(alloc_sel);
            end else begin
              resp_kind_d = KIND_NONE;
            end
          end
          OP_FREE, OP_START: begin
            if (in_pool_q) begin
              if (status_q[tid_q] == ST_RUN) begin
                cmd.op  = CELL_MARK;
                step_d  = '0;
                state_d = S_STEP;
              end else if (op_q == OP_START) begin
                state_d = S_INSERT;
              end else begin
                st_we = 1'b1;
              end
            end
          end
          OP_SET: begin
            pl_we = in_pool_q;
          end
          OP_TICK: begin
            tick_d    = tick_q + 32'd1;
            exp_cnt_d = '0;
            state_d   = S_EXPIRE;
          end
          default: ;
        endcase
      end
      S_STEP: begin
        cmd.op = CELL_STEP;
        step_d = step_q + 1'b1;
        if (step_q == TIMER_W'(NUM_TIMERS - 1)) begin
          if (op_q == OP_START) begin
            state_d = S_INSERT;
          end else begin
            st_we   = 1'b1;
            state_d = S_RESP;
          end
        end
      end
      S_INSERT: begin
        cmd.op  = CELL_INSERT;
        st_we   = 1'b1;
        st_val  = ST_RUN;
        state_d = S_RESP;
      end
      S_EXPIRE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_exp) begin
            cmd.op     = CELL_POP;
            st_we      = 1'b1;
            st_idx     = cells[0].id;
            st_val     = ST_ALLOC;
            out_kind_d = KIND_EXPIRED;
            out_id_d   = 4'(cells[0].id);
            out_data_d = payload_q[cells[0].id];
            out_last_d = !next_exp || (exp_cnt_q == EXP_CNT_W'(MAX_RESULTS - 1));
            exp_cnt_d  = exp_cnt_q + 1'b1;
            if (out_last_d) begin
              state_d = S_IDLE;
            end
          end else begin
            // nothing due on this tick
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = resp_kind_q;
          out_id_d   = resp_id_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (st_we) begin
        status_q[st_idx] <= st_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      tid_q     <= TIMER_W'(timer_index_i);
      in_pool_q <= (32'(timer_index_i) < 32'(NUM_TIMERS));
      dl_q      <= tick_q + delay_ticks_i;
      data_q    <= payload_i;
    end
    step_q      <= step_d;
    exp_cnt_q   <= exp_cnt_d;
    resp_kind_q <= resp_kind_d;
    resp_id_q   <= resp_id_d;
    if (pl_we) begin
      payload_q[tid_q] <= data_q;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign timer_id_o     = out_id_q;
  assign expired_data_o = out_data_q;
  assign last_o         = out_last_q;

endmodule

// File: hdl/sttp_checker.sv
`include "sorted_timeout_timer_pool_core_defines.svh"

module sttp_checker import sttp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [3:0]  timer_id_o,
  input logic [31:0] expired_data_o,
  input logic        last_o
);

  logic        stalled;
  logic [38:0] res_w;
  logic        plain_res, empty_res;
  logic        alloc_res, alloc_ok;

  assign stalled   = out_valid_o && !out_ready_i;
  assign res_w     = {kind_o, timer_id_o, expired_data_o, last_o};
  assign plain_res = out_valid_o && (kind_o == KIND_DONE || kind_o == KIND_NONE);
  assign empty_res = last_o && timer_id_o == 4'd0 && expired_data_o == 32'd0;
  assign alloc_res = out_valid_o && kind_o == KIND_ALLOC;
  assign alloc_ok  = last_o && expired_data_o == 32'd0;

  // a stalled result holds
  `STTP_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(res_w), "stalled result changed")

  // done and none-free results are single, empty and final
  `STTP_ASSERT_NOW(a_plain_result, plain_res, empty_res, "bad done or none-free result")

  // allocation is a single result with no data
  `STTP_ASSERT_NOW(a_alloc_result, alloc_res, alloc_ok, "bad allocation result")

  // one operation at a time
  `STTP_ASSERT_NEXT(a_one_op, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

endmodule

bind sorted_timeout_timer_pool_core sttp_checker u_sttp_checker (.*);
